[rtl/core/generalized_unifrac_pairwise_assert.svh]
// Assertion macros shared by the checker of the generalized UniFrac block.
// Depends on nothing; included by files that assert.
`ifndef GENERALIZED_UNIFRAC_PAIRWISE_ASSERT_SVH
`define GENERALIZED_UNIFRAC_PAIRWISE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define GUF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GUF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[rtl/core/guf_pkg.sv]
// Package of the generalized UniFrac block: widths and shared types.
// Depends on nothing.
package guf_pkg;
   localparam int AbW  = 17;
   localparam int LenW = 32;
   localparam int SumW = 128;
   localparam int QBits = 17;
   localparam logic [AbW-1:0] OneQ16 = 17'h10000;

   // One branch contribution: its difference ratio and its three weights.
   typedef struct packed {
      logic [16:0] diff;
      logic [63:0] w0;
      logic [95:0] w5;
      logic [95:0] w1;
   } term_type;
endpackage

[rtl/core/guf_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module guf_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/core/guf_seqdiv.sv]
// Shared bit-serial divider and square-root unit: one quotient or root bit per cycle.
// Depends on guf_pkg.
module guf_seqdiv (
   input  logic         clock,
   input  logic         reset,
   input  logic         div_start,
   input  logic [127:0] div_num,
   input  logic [127:0] div_den,
   input  logic [5:0]   div_bits,
   input  logic         sqrt_mode,
   output logic         div_done,
   output logic [63:0]  div_quot
);
   import guf_pkg::*;
   // Divide: restoring, quotient bits from (div_bits-1) down to 0.
   // Root: digit-by-digit integer square root on div_num, div_bits root bits.
   logic [127:0] rem_ff, rem_in;
   logic [127:0] den_ff, den_in;
   logic [63:0]  q_ff, q_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in, done_ff, done_in, sq_ff, sq_in;
   logic [127:0] trial;
   logic [127:0] sbit;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sq_in   = sq_ff;
      done_in = 1'b0;
      trial   = '0;
      sbit    = '0;
      if (div_start) begin
         rem_in  = div_num;
         den_in  = div_den;
         q_in    = '0;
         cnt_in  = div_bits;
         busy_in = 1'b1;
         sq_in   = sqrt_mode;
      end else if (busy_ff) begin
         if (sq_ff) begin
            sbit = 128'd1 << {cnt_ff - 6'd1, 1'b0};
            trial = {64'd0, q_ff} + sbit;
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               q_in   = 64'((({64'd0, q_ff} >> 1) + sbit));
            end else begin
               q_in = q_ff >> 1;
            end
         end else begin
            trial = den_ff << (cnt_ff - 6'd1);
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               q_in   = q_ff | (64'd1 << (cnt_ff - 6'd1));
            end
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      sq_ff  <= sq_in;
   end

   assign div_done = done_ff;
   assign div_quot = q_ff;
endmodule

[rtl/core/generalized_unifrac_pairwise.sv]
// Top level of the generalized UniFrac pairwise distance block.
// Depends on guf_pkg, guf_ram and guf_seqdiv.
//
// Load items are written into on-chip memories at one item per cycle while
// busy is low: the abundance memory holds MAX_SAMPLES x MAX_BRANCHES
// entries and the length and weight memories one entry per branch. The
// item with last set is stored like the others and then starts the walk over
// every sample pair (i > j), i rising from 1, j from 0 to i-1. For each pair
// the branches are visited one after another. A branch whose two abundances
// sum to zero passes through the read state, the sum state that fetches both
// abundances, the weight state and the accumulate state. Any other branch in
// addition uses the shared serial unit to form the root of the abundance sum
// and the Q1.16 difference ratio, and a 32 x 18 multiplier then forms the
// weights and the numerator terms. At the end of a pair three divisions form
// the three distances, or the distances are set to zero when the pair is
// empty, and one result item is strobed on rsp_valid for a single cycle; the
// receiver cannot stall it. busy is high from the last item until the final
// result item (last_pair) has been strobed; start is ignored then.
module generalized_unifrac_pairwise #(
   parameter int MAX_SAMPLES  = 8,
   parameter int MAX_BRANCHES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_branch,
   input  logic [2:0]  req_sample,
   input  logic [16:0] req_abundance,
   input  logic [31:0] req_branch_length,
   input  logic [31:0] req_branch_weight,
   input  logic        req_last,
   output logic        rsp_valid,
   output logic [2:0]  rsp_row_sample,
   output logic [2:0]  rsp_col_sample,
   output logic [16:0] rsp_dist_alpha0,
   output logic [16:0] rsp_dist_alpha_half,
   output logic [16:0] rsp_dist_alpha1,
   output logic        rsp_empty_pair,
   output logic        rsp_last_pair,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import guf_pkg::*;

   localparam int SW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int BW  = (MAX_BRANCHES > 1) ? $clog2(MAX_BRANCHES) : 1;
   localparam int AW  = $clog2(MAX_SAMPLES * MAX_BRANCHES);
   localparam int CSW = $clog2(MAX_SAMPLES + 1);
   localparam int CBW = $clog2(MAX_BRANCHES + 1);
   localparam logic [0:0] RegSamples  = 1'b0;
   localparam logic [0:0] RegBranches = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PAIR, ST_RD, ST_SUM, ST_SQRT, ST_DIFF, ST_MUL0, ST_MUL1,
      ST_ACC, ST_DIV, ST_EMIT
   } state_type;

   state_type   state_ff;
   logic [3:0]  ns_cfg_ff;
   logic [8:0]  nb_cfg_ff;
   logic [SW-1:0] i_ff, j_ff, ns_m1;
   logic [CBW-1:0] k_ff, nb_sat;
   logic [CSW-1:0] ns_sat;
   logic [1:0]  dsel_ff;
   logic [SumW-1:0] num_ff [3];
   logic [SumW-1:0] den_ff [3];
   logic [16:0] dist_ff [3];
   logic [17:0] s_ff;
   logic [16:0] dif_ff;
   logic [17:0] r_ff;
   logic [3:0]  mstep_ff;
   term_type    term_ff;
   logic        side_ff;
   logic [16:0] a_ff;

   // Write side of the stores.
   logic        in_acc;
   logic [16:0] ab_sat;
   logic        br_ok, sm_ok;
   assign in_acc = start && !busy;
   assign ab_sat = (req_abundance > OneQ16) ? OneQ16 : req_abundance;
   assign br_ok  = {24'd0, req_branch} < MAX_BRANCHES;
   assign sm_ok  = {29'd0, req_sample} < MAX_SAMPLES;

   logic [AW-1:0] ab_waddr, ab_raddr;
   logic [16:0]   ab_rdata;
   logic [31:0]   len_rdata, wt_rdata;
   assign ab_waddr = AW'(32'(req_sample) * 32'(MAX_BRANCHES) + 32'(req_branch));
   assign ab_raddr = AW'(32'(side_ff ? j_ff : i_ff) * 32'(MAX_BRANCHES) + 32'(k_ff));

   guf_ram #(.Width(17), .Depth(MAX_SAMPLES * MAX_BRANCHES)) u_ab (
      .clock, .wr_en(in_acc && br_ok && sm_ok), .wr_addr(ab_waddr),
      .wr_data(ab_sat), .rd_addr(ab_raddr), .rd_data(ab_rdata));
   guf_ram #(.Width(32), .Depth(MAX_BRANCHES)) u_len (
      .clock, .wr_en(in_acc && br_ok), .wr_addr(BW'(req_branch)),
      .wr_data(req_branch_length), .rd_addr(k_ff[BW-1:0]), .rd_data(len_rdata));
   guf_ram #(.Width(32), .Depth(MAX_BRANCHES)) u_wt (
      .clock, .wr_en(in_acc && br_ok), .wr_addr(BW'(req_branch)),
      .wr_data(req_branch_weight), .rd_addr(k_ff[BW-1:0]), .rd_data(wt_rdata));

   // Saturated counts.
   always_comb begin
      if (ns_cfg_ff < 4'd2) ns_sat = CSW'(2);
      else if ({28'd0, ns_cfg_ff} > MAX_SAMPLES) ns_sat = CSW'(MAX_SAMPLES);
      else ns_sat = CSW'(ns_cfg_ff);
      if (nb_cfg_ff == 9'd0) nb_sat = CBW'(1);
      else if ({23'd0, nb_cfg_ff} > MAX_BRANCHES) nb_sat = CBW'(MAX_BRANCHES);
      else nb_sat = CBW'(nb_cfg_ff);
      ns_m1 = SW'(ns_sat - CSW'(1));
   end

   // Shared serial unit.
   logic         dv_start, dv_sqrt, dv_done;
   logic [127:0] dv_num, dv_den;
   logic [5:0]   dv_bits;
   logic [63:0]  dv_q;
   guf_seqdiv u_div (
      .clock, .reset, .div_start(dv_start), .div_num(dv_num), .div_den(dv_den),
      .div_bits(dv_bits), .sqrt_mode(dv_sqrt), .div_done(dv_done), .div_quot(dv_q));

   always_comb begin
      dv_start = 1'b0;
      dv_sqrt  = 1'b0;
      dv_num   = '0;
      dv_den   = '0;
      dv_bits  = 6'd17;
      case (state_ff)
         ST_MUL0: begin
            if (s_ff != '0) begin
               dv_start = 1'b1;
               dv_sqrt  = 1'b1;
               dv_bits  = 6'd18;
               dv_num   = {94'd0, s_ff, 16'd0};
            end
         end
         ST_SQRT: begin
            if (dv_done) begin
               dv_start = 1'b1;
               dv_num   = {95'd0, dif_ff, 16'd0};
               dv_den   = {110'd0, s_ff};
            end
         end
         ST_DIV: begin
            if ((dv_done || dsel_ff == 2'd0) && dsel_ff != 2'd3 && den_ff[0] != '0) begin
               dv_start = 1'b1;
               dv_num   = num_ff[dsel_ff];
               dv_den   = den_ff[dsel_ff];
            end
         end
         default: ;
      endcase
   end

   // Weight and numerator terms, one 32 x 18 partial product per cycle.
   // Steps 0-1 form w5, 2-3 form w1, then w0, w5 and w1 are scaled by diff.
   logic [31:0]     m_a;
   logic [17:0]     m_b;
   logic [1:0]      m_sh;
   logic [49:0]     m_p;
   logic [SumW-1:0] m_term;
   always_comb begin
      m_a  = '0;
      m_sh = 2'd0;
      case (mstep_ff)
         4'd0, 4'd2, 4'd4: m_a = term_ff.w0[31:0];
         4'd1, 4'd3, 4'd5: begin
            m_a  = term_ff.w0[63:32];
            m_sh = 2'd1;
         end
         4'd6: m_a = term_ff.w5[31:0];
         4'd7: begin
            m_a  = term_ff.w5[63:32];
            m_sh = 2'd1;
         end
         4'd8: begin
            m_a  = term_ff.w5[95:64];
            m_sh = 2'd2;
         end
         4'd9: m_a = term_ff.w1[31:0];
         4'd10: begin
            m_a  = term_ff.w1[63:32];
            m_sh = 2'd1;
         end
         4'd11: begin
            m_a  = term_ff.w1[95:64];
            m_sh = 2'd2;
         end
         default: ;
      endcase
      if (mstep_ff < 4'd2) m_b = r_ff;
      else if (mstep_ff < 4'd4) m_b = s_ff;
      else m_b = {1'b0, term_ff.diff};
      m_p    = {18'd0, m_a} * {32'd0, m_b};
      m_term = SumW'(m_p) << {m_sh, 5'd0};
   end

   logic [16:0] b_now;
   assign b_now = ab_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ns_cfg_ff <= 4'd8;
         nb_cfg_ff <= 9'd256;
         rsp_valid <= 1'b0;
         busy      <= 1'b0;
         side_ff   <= 1'b0;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         dsel_ff   <= '0;
         mstep_ff  <= '0;
         rsp_last_pair <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               RegSamples:  ns_cfg_ff <= csr_data[3:0];
               RegBranches: nb_cfg_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (in_acc && req_last) begin
                  busy     <= 1'b1;
                  i_ff     <= SW'(1);
                  j_ff     <= '0;
                  state_ff <= ST_PAIR;
               end
            end
            ST_PAIR: begin
               for (int x = 0; x < 3; x++) begin
                  num_ff[x] <= '0;
                  den_ff[x] <= '0;
               end
               k_ff     <= '0;
               side_ff  <= 1'b0;
               state_ff <= ST_RD;
            end
            ST_RD: begin
               // Address for sample i is presented; switch to sample j.
               side_ff  <= 1'b1;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               if (!side_ff) begin
                  s_ff     <= 18'(a_ff) + 18'(b_now);
                  dif_ff   <= (a_ff > b_now) ? a_ff - b_now : b_now - a_ff;
                  state_ff <= ST_MUL0;
               end else begin
                  a_ff    <= ab_rdata;
                  side_ff <= 1'b0;
               end
            end
            ST_MUL0: begin
               term_ff.w0 <= 64'(len_rdata) * 64'(wt_rdata);
               state_ff   <= (s_ff == '0) ? ST_ACC : ST_SQRT;
            end
            ST_SQRT: begin
               if (dv_done) begin
                  r_ff     <= dv_q[17:0];
                  state_ff <= ST_DIFF;
               end
            end
            ST_DIFF: begin
               if (dv_done) begin
                  term_ff.diff <= dv_q[16:0];
                  term_ff.w5   <= '0;
                  term_ff.w1   <= '0;
                  mstep_ff     <= '0;
                  state_ff     <= ST_MUL1;
               end
            end
            ST_MUL1: begin
               if (mstep_ff < 4'd2) term_ff.w5 <= term_ff.w5 + m_term[95:0];
               else if (mstep_ff < 4'd4) term_ff.w1 <= term_ff.w1 + m_term[95:0];
               else if (mstep_ff < 4'd6) num_ff[0] <= num_ff[0] + m_term;
               else if (mstep_ff < 4'd9) num_ff[1] <= num_ff[1] + m_term;
               else num_ff[2] <= num_ff[2] + m_term;
               mstep_ff <= mstep_ff + 4'd1;
               if (mstep_ff == 4'd11) state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (s_ff != '0) begin
                  den_ff[0] <= den_ff[0] + SumW'(term_ff.w0);
                  den_ff[1] <= den_ff[1] + SumW'(term_ff.w5);
                  den_ff[2] <= den_ff[2] + SumW'(term_ff.w1);
               end
               if (k_ff == nb_sat - CBW'(1)) begin
                  dsel_ff  <= '0;
                  state_ff <= ST_DIV;
               end else begin
                  k_ff     <= k_ff + CBW'(1);
                  side_ff  <= 1'b0;
                  state_ff <= ST_RD;
               end
            end
            ST_DIV: begin
               if (den_ff[0] == '0) begin
                  for (int x = 0; x < 3; x++) dist_ff[x] <= '0;
                  state_ff <= ST_EMIT;
               end else if (dv_done) begin
                  dist_ff[dsel_ff - 2'd1] <= dv_q[16:0];
                  if (dsel_ff == 2'd3) state_ff <= ST_EMIT;
                  else dsel_ff <= dsel_ff + 2'd1;
               end else if (dsel_ff == 2'd0) begin
                  dsel_ff <= 2'd1;
               end
            end
            ST_EMIT: begin
               rsp_valid      <= 1'b1;
               rsp_row_sample <= 3'(i_ff);
               rsp_col_sample <= 3'(j_ff);
               rsp_dist_alpha0     <= dist_ff[0];
               rsp_dist_alpha_half <= dist_ff[1];
               rsp_dist_alpha1     <= dist_ff[2];
               rsp_empty_pair <= (den_ff[0] == '0);
               rsp_last_pair  <= (i_ff == ns_m1) && (j_ff == i_ff - SW'(1));
               if (i_ff == ns_m1 && j_ff == i_ff - SW'(1)) begin
                  busy     <= 1'b0;
                  state_ff <= ST_IDLE;
               end else begin
                  if (j_ff == i_ff - SW'(1)) begin
                     i_ff <= i_ff + SW'(1);
                     j_ff <= '0;
                  end else begin
                     j_ff <= j_ff + SW'(1);
                  end
                  state_ff <= ST_PAIR;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

[rtl/core/guf_checker.sv]
// Port checker for the generalized UniFrac block, bound to the top level.
// Depends on the assertion macro header.
`include "generalized_unifrac_pairwise_assert.svh"
module guf_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_last_pair,
   input logic       rsp_empty_pair,
   input logic [2:0] rsp_row_sample,
   input logic [2:0] rsp_col_sample,
   input logic [16:0] rsp_dist_alpha0
);
   `GUF_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid && !rsp_last_pair, busy)
   `GUF_ASSERT_IMP(a_pair_order, clock, reset, rsp_valid, rsp_row_sample > rsp_col_sample)
   `GUF_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid && rsp_empty_pair,
                   rsp_dist_alpha0 == 17'd0)
   `GUF_ASSERT_NEXT(a_no_back, clock, reset, rsp_valid, !rsp_valid)
endmodule

bind generalized_unifrac_pairwise guf_checker u_guf_checker (.*);

[tb/tb_generalized_unifrac_pairwise.sv]
// Self-checking testbench of the generalized UniFrac pairwise distance block.
// Depends on guf_pkg and the generalized_unifrac_pairwise RTL.
// Loads abundance sets under many register settings and predicts every pair result.
`timescale 1ns / 100ps

module tb_generalized_unifrac_pairwise;
   import guf_pkg::*;

   // Register indexes of the configuration port.
   localparam logic [0:0] RegSamples  = 1'b0;
   localparam logic [0:0] RegBranches = 1'b1;

   // Content styles of one loaded data set.
   typedef enum int {MixRandom, MixSparse, MixEmpty, MixExtreme} mix_type;

   localparam int NumSamples  = 8;
   localparam int NumBranches = 256;
   localparam int StallLimit  = 40000;
   localparam int ItemGoal    = 480;

   typedef struct {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [16:0] d0;
      logic [16:0] dh;
      logic [16:0] d1;
      logic        empty;
      logic        last;
   } pair_type;

   // Keeps its own copy of the block's memories and registers, and the
   // pair distances that are still to come out.
   class scoreboard_type;
      logic [AbW-1:0] abund [NumSamples*NumBranches];
      logic [31:0]    len_mem [NumBranches];
      logic [31:0]    wt_mem [NumBranches];
      logic [3:0]     samples_reg;
      logic [8:0]     branches_reg;
      pair_type       due [$];
      int             errors;

      function new();
         samples_reg  = 4'd8;
         branches_reg = 9'd256;
         errors       = 0;
      endfunction

      function void write_reg(logic [0:0] idx, logic [8:0] data);
         if (idx == RegSamples) samples_reg = data[3:0];
         else branches_reg = data;
      endfunction

      function logic [63:0] root_q16(logic [63:0] v);
         logic [63:0] r, t;
         r = 0;
         for (int b = 17; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      // Stores one accepted item and, for the last item, predicts every pair.
      function void note_item(logic [7:0] br, logic [2:0] sm, logic [16:0] ab,
                              logic [31:0] ln, logic [31:0] wt, logic lst);
         int ns, nb;
         logic [16:0]  a, b;
         logic [63:0]  s, dif, diff, w0;
         logic [127:0] w [3];
         logic [127:0] num [3];
         logic [127:0] den [3];
         pair_type     p;
         if (ab > OneQ16) ab = OneQ16;
         len_mem[br] = ln;
         wt_mem[br]  = wt;
         abund[sm*NumBranches + br] = ab;
         if (!lst) return;
         ns = samples_reg < 2 ? 2 : (samples_reg > NumSamples ? NumSamples : samples_reg);
         nb = branches_reg < 1 ? 1 :
              (branches_reg > NumBranches ? NumBranches : branches_reg);
         for (int i = 1; i < ns; i++) begin
            for (int j = 0; j < i; j++) begin
               for (int x = 0; x < 3; x++) begin
                  num[x] = 0;
                  den[x] = 0;
               end
               for (int k = 0; k < nb; k++) begin
                  a = abund[i*NumBranches + k];
                  b = abund[j*NumBranches + k];
                  s = a + b;
                  if (s != 0) begin
                     dif  = a > b ? a - b : b - a;
                     diff = (dif << 16) / s;
                     w0   = len_mem[k] * wt_mem[k];
                     w[0] = w0;
                     w[1] = 128'(w0) * root_q16(s << 16);
                     w[2] = 128'(w0) * s;
                     for (int x = 0; x < 3; x++) begin
                        den[x] += w[x];
                        num[x] += w[x] * diff;
                     end
                  end
               end
               p.row = i[2:0];
               p.col = j[2:0];
               p.empty = (den[0] == 0);
               p.d0 = p.empty ? 17'd0 : 17'(num[0] / den[0]);
               p.dh = p.empty ? 17'd0 : 17'(num[1] / den[1]);
               p.d1 = p.empty ? 17'd0 : 17'(num[2] / den[2]);
               p.last = (i == ns - 1 && j == i - 1);
               due.push_back(p);
            end
         end
      endfunction

      function void check_pair(pair_type got);
         pair_type e;
         if (due.size() == 0) begin
            $error("result for pair %0d,%0d with nothing expected", got.row, got.col);
            errors++;
            return;
         end
         e = due.pop_front();
         if (got.row !== e.row) begin
            $error("row_sample: expected %0d, got %0d", e.row, got.row); errors++;
         end
         if (got.col !== e.col) begin
            $error("col_sample: expected %0d, got %0d", e.col, got.col); errors++;
         end
         if (got.d0 !== e.d0) begin
            $error("dist_alpha0: expected %0d, got %0d", e.d0, got.d0); errors++;
         end
         if (got.dh !== e.dh) begin
            $error("dist_alpha_half: expected %0d, got %0d", e.dh, got.dh); errors++;
         end
         if (got.d1 !== e.d1) begin
            $error("dist_alpha1: expected %0d, got %0d", e.d1, got.d1); errors++;
         end
         if (got.empty !== e.empty) begin
            $error("empty_pair: expected %0d, got %0d", e.empty, got.empty); errors++;
         end
         if (got.last !== e.last) begin
            $error("last_pair: expected %0d, got %0d", e.last, got.last); errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_branch = '0;
   logic [2:0]  req_sample = '0;
   logic [16:0] req_abundance = '0;
   logic [31:0] req_branch_length = '0;
   logic [31:0] req_branch_weight = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic [2:0]  rsp_row_sample;
   logic [2:0]  rsp_col_sample;
   logic [16:0] rsp_dist_alpha0;
   logic [16:0] rsp_dist_alpha_half;
   logic [16:0] rsp_dist_alpha1;
   logic        rsp_empty_pair;
   logic        rsp_last_pair;
   logic        csr_write = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [8:0]  csr_data = '0;

   scoreboard_type sb = new();

   // Entries of the abundance memory written so far. A pair walk only ever
   // reads entries marked here, since unwritten memory is undefined.
   bit loaded [NumSamples*NumBranches];
   int items_sent = 0;
   bit gaps_on = 1'b1;
   int stall_count = 0;

   always #10 clock = ~clock;

   generalized_unifrac_pairwise DUT (.*);

   // Monitor: items and results are taken at the rising edge, where the
   // block's outputs still hold the values of the cycle that ends there.
   always @(posedge clock) begin
      pair_type got;
      if (!reset) begin
         if (start && !busy)
            sb.note_item(req_branch, req_sample, req_abundance,
                         req_branch_length, req_branch_weight, req_last);
         if (rsp_valid) begin
            got.row   = rsp_row_sample;
            got.col   = rsp_col_sample;
            got.d0    = rsp_dist_alpha0;
            got.dh    = rsp_dist_alpha_half;
            got.d1    = rsp_dist_alpha1;
            got.empty = rsp_empty_pair;
            got.last  = rsp_last_pair;
            sb.check_pair(got);
         end
         // Watchdog on cycles in which neither side moves anything. The
         // longest correct gap is one pair walked over all 256 branches.
         if ((start && !busy) || rsp_valid) stall_count <= 0;
         else if (stall_count >= StallLimit) begin
            $display("tb_generalized_unifrac_pairwise: FAIL");
            $finish;
         end else stall_count <= stall_count + 1;
      end
   end

   // Sends one item, with a random idle burst before it while gaps are on.
   // The item stays on the ports until an edge with busy low takes it.
   task automatic send_item(logic [7:0] br, logic [2:0] sm, logic [16:0] ab,
                            logic [31:0] ln, logic [31:0] wt, logic lst);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end else @(negedge clock);
      start <= 1'b1;
      req_branch <= br;
      req_sample <= sm;
      req_abundance <= ab;
      req_branch_length <= ln;
      req_branch_weight <= wt;
      req_last <= lst;
      do @(posedge clock); while (busy);
      loaded[sm*NumBranches + br] = 1'b1;
      items_sent++;
      if (items_sent > ItemGoal * 17 / 20) gaps_on = 1'b0;
   endtask

   function automatic logic [16:0] pick_abundance(mix_type mix);
      case (mix)
         MixEmpty: return 17'd0;
         MixSparse: return $urandom_range(0, 2) != 0 ? 17'd0 : 17'($urandom_range(1, 65536));
         MixExtreme: begin
            case ($urandom_range(0, 3))
               0: return 17'd0;
               1: return OneQ16;
               2: return 17'h1FFFF;
               default: return 17'($urandom_range(65537, 131071));
            endcase
         end
         default: return $urandom_range(0, 4) == 0 ? 17'd0 : 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [31:0] pick_word(mix_type mix);
      if (mix == MixExtreme || $urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 2))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return 32'd65536;
         endcase
      end
      return $urandom();
   endfunction

   // Takes the last item off the ports, then waits until the block has
   // delivered everything and gone idle, so that the registers may be
   // rewritten safely.
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (sb.due.size() != 0 || busy);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [8:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      sb.write_reg(idx, data);
   endtask

   // One phase: set the registers, load some random items, fill every entry
   // that the walk will read and was never written, then send the last item.
   task automatic run_set(logic [8:0] ns_raw, logic [8:0] nb_raw, mix_type mix,
                          int extras);
      int ns, nb;
      ns = ns_raw[3:0] < 2 ? 2 : (ns_raw[3:0] > 8 ? 8 : ns_raw[3:0]);
      nb = nb_raw < 1 ? 1 : (nb_raw > 256 ? 256 : nb_raw);
      wait_idle();
      write_reg(RegSamples, ns_raw);
      write_reg(RegBranches, nb_raw);
      // An empty set must clear every entry in range, old ones included.
      if (mix == MixEmpty)
         for (int s = 0; s < ns; s++)
            for (int k = 0; k < nb; k++) loaded[s*NumBranches + k] = 1'b0;
      for (int n = 0; n < extras; n++) begin
         // Some items go anywhere in memory, also outside the walked range.
         if ($urandom_range(0, 4) == 0)
            send_item(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                      17'($urandom_range(0, 131071)), $urandom(), $urandom(), 1'b0);
         else if (mix != MixEmpty)
            send_item(8'($urandom_range(0, nb - 1)), 3'($urandom_range(0, ns - 1)),
                      pick_abundance(mix), pick_word(mix), pick_word(mix), 1'b0);
      end
      for (int s = 0; s < ns; s++)
         for (int k = 0; k < nb; k++)
            if (!loaded[s*NumBranches + k])
               send_item(8'(k), 3'(s), pick_abundance(mix), pick_word(mix),
                         pick_word(mix), 1'b0);
      send_item(8'($urandom_range(0, nb - 1)), 3'($urandom_range(0, ns - 1)),
                pick_abundance(mix), pick_word(mix), pick_word(mix), 1'b1);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed sets: the smallest pair with one branch, an all-zero set
      // that must give empty pairs, saturated abundances with extreme lengths
      // and weights, and register values beyond their ranges.
      run_set(9'd2, 9'd1, MixExtreme, 2);
      run_set(9'd2, 9'd1, MixEmpty, 0);
      run_set(9'd3, 9'd2, MixExtreme, 3);
      run_set(9'd15, 9'd0, MixRandom, 2);
      run_set(9'd1, 9'd3, MixSparse, 2);

      while (items_sent < ItemGoal) begin
         case ($urandom_range(0, 9))
            0: run_set(9'($urandom_range(0, 15)), 9'($urandom_range(0, 10)),
                       MixEmpty, $urandom_range(0, 4));
            1, 2: run_set(9'($urandom_range(2, 8)), 9'($urandom_range(1, 8)),
                          MixSparse, $urandom_range(0, 12));
            3: run_set(9'($urandom_range(0, 15)), 9'($urandom_range(0, 8)),
                       MixExtreme, $urandom_range(0, 12));
            4: run_set(9'($urandom_range(2, 4)), 9'($urandom_range(10, 24)),
                       MixRandom, $urandom_range(0, 12));
            default: run_set(9'($urandom_range(2, 8)), 9'($urandom_range(1, 8)),
                             MixRandom, $urandom_range(0, 12));
         endcase
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.due.size() == 0)
         $display("tb_generalized_unifrac_pairwise: PASS");
      else
         $display("tb_generalized_unifrac_pairwise: FAIL");
      $finish;
   end
endmodule

[generalized_unifrac_pairwise.f]
+incdir+rtl/core
rtl/core/guf_pkg.sv
rtl/core/guf_ram.sv
rtl/core/guf_seqdiv.sv
rtl/core/generalized_unifrac_pairwise.sv
rtl/core/guf_checker.sv
tb/tb_generalized_unifrac_pairwise.sv
